// ===== sv/ksel_pkg.sv =====
// Shared types and constants for the k-smallest selector with sorted drain.
// No dependencies; used by ksel_cmp and k_smallest_selector_sorted_drain.
package ksel_pkg;

	localparam int STORE_DEPTH_DEF = 32;
	localparam int KEEP_W          = 7;
	localparam int CODE_W          = 48;
	localparam int SCORE_W         = 32;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd32;

	localparam logic REQ_OFFER = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0]         code;
		logic signed [SCORE_W-1:0] score;
	} rec_t;

	typedef struct packed {
		logic                      req_type;
		logic [CODE_W-1:0]         rec_code;
		logic signed [SCORE_W-1:0] rec_score;
	} cmd_t;

	typedef struct packed {
		logic [CODE_W-1:0]         out_code;
		logic signed [SCORE_W-1:0] out_score;
		logic                      out_last;
	} rsp_t;

	// a_worse: a ranks worse (score, then code); a_less: a sorts first (code, then score)
	typedef struct packed {
		logic a_worse;
		logic a_less;
		logic a_equal;
	} cmp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESCAN,
		ST_SORT,
		ST_EMIT
	} state_t;

endpackage

// ===== sv/ksel_cmp.sv =====
// Record comparator: rank order (score, code) and sort order (code, score).
// Depends on ksel_pkg.
module ksel_cmp import ksel_pkg::*; (
	input  rec_t a,
	input  rec_t b,
	output cmp_t res
);

	logic [CODE_W+SCORE_W-1:0] rank_a, rank_b, sort_a, sort_b;

	always_comb begin
		rank_a = {~a.score[SCORE_W-1], a.score[SCORE_W-2:0], a.code};
		rank_b = {~b.score[SCORE_W-1], b.score[SCORE_W-2:0], b.code};
		sort_a = {a.code, ~a.score[SCORE_W-1], a.score[SCORE_W-2:0]};
		sort_b = {b.code, ~b.score[SCORE_W-1], b.score[SCORE_W-2:0]};
		res.a_worse = rank_a > rank_b;
		res.a_less  = sort_a < sort_b;
		res.a_equal = a == b;
	end

endmodule

// ===== sv/k_smallest_selector_sorted_drain.sv =====
// Top level of the k-smallest selector: record store, rescan and sorted drain.
// Depends on ksel_pkg and ksel_cmp.
//
// Usage:
//   cmd is taken at a clock edge with start high and busy low. An offer
//   (req_type 0) fills a free slot, or replaces the worst held record when it
//   ranks better; a drain (req_type 1) emits the held records in ascending
//   code order (equal codes by ascending score) and empties the store.
//   Each result sits on rsp for one cycle with rsp_strobe high; the last
//   record of a drain has out_last set. The receiver cannot stall.
//   keep_count_we writes keep_count; the user must do so only while busy
//   is low, as the block itself does not enforce it.
//   An offer that fills a slot or is dropped leaves busy low.
//   An offer that replaces raises busy for a rescan that reads one entry per
//   cycle through the single read port of the store memory.
//   A drain runs one scan of the held records per distinct record, then emits
//   the records equal to it; an empty drain leaves busy low.
// Reset: store empty, keep_count 32; the memory is not cleared.
module k_smallest_selector_sorted_drain import ksel_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cmd_t              cmd,
	output logic              rsp_strobe,
	output rsp_t              rsp,
	input  logic              keep_count_we,
	input  logic [KEEP_W-1:0] keep_count_wdata
);

	localparam int SLOT_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

	rec_t mem [STORE_DEPTH];

	state_t state_q, state_d;

	logic [KEEP_W-1:0] keep_q, keep_eff;
	logic [CNT_W-1:0]  fill_q, rd_idx_q, emit_q, best_cnt_q;
	logic [SLOT_W-1:0] worst_slot_q, cand_slot_q, idx_s1;
	logic              valid_s1, last_s1, have_prev_q, best_valid_q;
	rec_t              worst_rec_q, cand_rec_q, prev_rec_q, best_rec_q, rdata_s1, new_rec;

	logic              accept, issuing, has_room, replace, pass_done, emit_done, drain_done;
	logic              mem_we, elig, cand_take;
	logic [SLOT_W-1:0] mem_waddr;
	cmp_t              cmp_new, cmp_cand, cmp_best, cmp_prev;

	assign new_rec = '{code: cmd.rec_code, score: cmd.rec_score};

	ksel_cmp u_cmp_new  (.a(new_rec),  .b(worst_rec_q), .res(cmp_new));
	ksel_cmp u_cmp_cand (.a(rdata_s1), .b(cand_rec_q),  .res(cmp_cand));
	ksel_cmp u_cmp_best (.a(rdata_s1), .b(best_rec_q),  .res(cmp_best));
	ksel_cmp u_cmp_prev (.a(prev_rec_q), .b(rdata_s1),  .res(cmp_prev));

	always_comb begin
		if (keep_q == '0)
			keep_eff = KEEP_W'(1);
		else if (keep_q > KEEP_W'(STORE_DEPTH))
			keep_eff = KEEP_W'(STORE_DEPTH);
		else
			keep_eff = keep_q;
	end

	assign accept     = start && (state_q == ST_IDLE);
	assign has_room   = KEEP_W'(fill_q) < keep_eff;
	assign replace    = !cmp_new.a_worse && !cmp_new.a_equal;
	assign issuing    = (state_q == ST_RESCAN || state_q == ST_SORT) && (rd_idx_q < fill_q);
	assign pass_done  = valid_s1 && last_s1;
	assign emit_done  = best_cnt_q == CNT_W'(1);
	assign drain_done = emit_q == fill_q - CNT_W'(1);
	assign elig       = !have_prev_q || cmp_prev.a_less;
	assign cand_take  = cmp_cand.a_worse;

	assign mem_we    = accept && (cmd.req_type == REQ_OFFER) && (has_room || replace);
	assign mem_waddr = has_room ? fill_q[SLOT_W-1:0] : worst_slot_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= new_rec;
		rdata_s1 <= mem[rd_idx_q[SLOT_W-1:0]];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.req_type == REQ_DRAIN) begin
						if (fill_q != '0)
							state_d = ST_SORT;
					end else if (!has_room && replace) begin
						state_d = ST_RESCAN;
					end
				end
			end
			ST_RESCAN: begin
				if (pass_done)
					state_d = ST_IDLE;
			end
			ST_SORT: begin
				if (pass_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_done)
					state_d = drain_done ? ST_IDLE : ST_SORT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy           = state_q != ST_IDLE;
		rsp_strobe     = state_q == ST_EMIT;
		rsp.out_code   = best_rec_q.code;
		rsp.out_score  = best_rec_q.score;
		rsp.out_last   = drain_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			keep_q       <= KEEP_RESET;
			fill_q       <= '0;
			worst_slot_q <= '0;
			rd_idx_q     <= '0;
			emit_q       <= '0;
			best_cnt_q   <= '0;
			valid_s1     <= 1'b0;
			last_s1      <= 1'b0;
			have_prev_q  <= 1'b0;
			best_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issuing;
			last_s1  <= issuing && (rd_idx_q == fill_q - CNT_W'(1));
			if (keep_count_we)
				keep_q <= keep_count_wdata;
			if (issuing)
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			else if (state_q == ST_IDLE || state_q == ST_EMIT)
				rd_idx_q <= '0;

			if (accept && cmd.req_type == REQ_OFFER && has_room) begin
				fill_q <= fill_q + CNT_W'(1);
				if (fill_q == '0 || cmp_new.a_worse)
					worst_slot_q <= fill_q[SLOT_W-1:0];
			end
			if (accept && cmd.req_type == REQ_DRAIN) begin
				emit_q       <= '0;
				have_prev_q  <= 1'b0;
				best_valid_q <= 1'b0;
				best_cnt_q   <= '0;
			end
			if (state_q == ST_RESCAN && pass_done)
				worst_slot_q <= cand_take ? idx_s1 : cand_slot_q;
			if (state_q == ST_SORT && valid_s1 && elig) begin
				if (!best_valid_q || cmp_best.a_less) begin
					best_valid_q <= 1'b1;
					best_cnt_q   <= CNT_W'(1);
				end else if (cmp_best.a_equal) begin
					best_cnt_q <= best_cnt_q + CNT_W'(1);
				end
			end
			if (state_q == ST_EMIT) begin
				emit_q     <= emit_q + CNT_W'(1);
				best_cnt_q <= best_cnt_q - CNT_W'(1);
				if (emit_done) begin
					have_prev_q  <= 1'b1;
					best_valid_q <= 1'b0;
					if (drain_done) begin
						fill_q       <= '0;
						worst_slot_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[SLOT_W-1:0];
		if (accept && cmd.req_type == REQ_OFFER) begin
			if (has_room) begin
				if (fill_q == '0 || cmp_new.a_worse)
					worst_rec_q <= new_rec;
			end else begin
				cand_slot_q <= worst_slot_q;
				cand_rec_q  <= new_rec;
			end
		end
		if (state_q == ST_RESCAN && valid_s1 && cand_take) begin
			cand_slot_q <= idx_s1;
			cand_rec_q  <= rdata_s1;
		end
		if (state_q == ST_RESCAN && pass_done)
			worst_rec_q <= cand_take ? rdata_s1 : cand_rec_q;
		if (state_q == ST_SORT && valid_s1 && elig && (!best_valid_q || cmp_best.a_less))
			best_rec_q <= rdata_s1;
		if (state_q == ST_EMIT && emit_done)
			prev_rec_q <= best_rec_q;
	end

`ifndef SYNTHESIS
	a_worst_held: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != '0 |-> CNT_W'(worst_slot_q) < fill_q)
		else $error("worst slot outside held records");
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe |-> $past(state_q) == ST_SORT || $past(state_q) == ST_EMIT)
		else $error("result item without a sort pass");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && rsp.out_last |=> !rsp_strobe && fill_q == '0 && !busy)
		else $error("store not cleared after last item");
	a_empty_drain: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.req_type == REQ_DRAIN && fill_q == '0 |=> !busy && !rsp_strobe)
		else $error("empty drain started work");
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> state_q == ST_RESCAN || state_q == ST_SORT)
		else $error("read data outside a scan");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for k_smallest_selector_sorted_drain: directed corner cases, then
// random offer/drain traffic over several keep_count settings, checked by a predictor.
// Depends on ksel_pkg and the selector RTL.
import ksel_pkg::*;

class topk_scoreboard;
	rec_t               held [STORE_DEPTH_DEF];
	int unsigned        fill_cnt;
	int unsigned        worst_idx;
	logic [KEEP_W-1:0]  keep_reg;
	rsp_t               expected_out [$];
	int                 errors;

	function new();
		fill_cnt  = 0;
		worst_idx = 0;
		keep_reg  = KEEP_RESET;
		errors    = 0;
	endfunction

	function bit ranks_worse(rec_t a, rec_t b);
		return ($signed(a.score) > $signed(b.score)) ||
			($signed(a.score) == $signed(b.score) && a.code > b.code);
	endfunction

	function bit sorts_after(rec_t a, rec_t b);
		return (a.code > b.code) || (a.code == b.code && $signed(a.score) > $signed(b.score));
	endfunction

	function int unsigned keep_limit();
		int unsigned k;
		k = keep_reg;
		if (k < 1)
			k = 1;
		if (k > STORE_DEPTH_DEF)
			k = STORE_DEPTH_DEF;
		return k;
	endfunction

	function void set_keep(logic [KEEP_W-1:0] v);
		keep_reg = v;
	endfunction

	function void note_request(cmd_t c);
		rec_t        r;
		rec_t        ordered [STORE_DEPTH_DEF];
		rsp_t        o;
		int unsigned a;
		int unsigned b;
		int unsigned w;
		r.code  = c.rec_code;
		r.score = c.rec_score;
		if (c.req_type == REQ_OFFER) begin
			if (fill_cnt < keep_limit()) begin
				held[fill_cnt] = r;
				if (fill_cnt == 0 || ranks_worse(r, held[worst_idx]))
					worst_idx = fill_cnt;
				fill_cnt++;
			end else if (ranks_worse(held[worst_idx], r)) begin
				held[worst_idx] = r;
				w = worst_idx;
				for (a = 0; a < fill_cnt; a++)
					if (ranks_worse(held[a], held[w]))
						w = a;
				worst_idx = w;
			end
		end else if (fill_cnt != 0) begin
			for (a = 0; a < fill_cnt; a++) begin
				b = a;
				while (b > 0 && sorts_after(ordered[b-1], held[a])) begin
					ordered[b] = ordered[b-1];
					b--;
				end
				ordered[b] = held[a];
			end
			for (a = 0; a < fill_cnt; a++) begin
				o.out_code  = ordered[a].code;
				o.out_score = ordered[a].score;
				o.out_last  = (a + 1 == fill_cnt);
				expected_out.push_back(o);
			end
			fill_cnt  = 0;
			worst_idx = 0;
		end
	endfunction

	task report(string msg);
		errors++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task check_record(rsp_t got);
		rsp_t exp_r;
		if (expected_out.size() == 0) begin
			report($sformatf("unexpected record code %h score %0d", got.out_code, got.out_score));
		end else begin
			exp_r = expected_out.pop_front();
			if (got.out_code !== exp_r.out_code)
				report($sformatf("out_code %h, want %h", got.out_code, exp_r.out_code));
			if (got.out_score !== exp_r.out_score)
				report($sformatf("out_score %0d, want %0d", got.out_score, exp_r.out_score));
			if (got.out_last !== exp_r.out_last)
				report($sformatf("out_last %b, want %b", got.out_last, exp_r.out_last));
		end
	endtask
endclass

module testbench;
	localparam int SETTLE = 2 * STORE_DEPTH_DEF + 8;
	localparam int STALL_LIMIT = 8000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	cmd_t              cmd = '0;
	logic              rsp_strobe;
	rsp_t              rsp;
	logic              keep_count_we = 1'b0;
	logic [KEEP_W-1:0] keep_count_wdata = '0;

	topk_scoreboard sb = new();
	bit             gaps_on = 1'b0;
	int             stall_cnt = 0;

	always #10 clk = ~clk;

	k_smallest_selector_sorted_drain #(
		.STORE_DEPTH(STORE_DEPTH_DEF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.rsp_strobe(rsp_strobe),
		.rsp(rsp),
		.keep_count_we(keep_count_we),
		.keep_count_wdata(keep_count_wdata)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(cmd);
			if (rsp_strobe)
				sb.check_record(rsp);
			if (keep_count_we)
				sb.set_keep(keep_count_wdata);
			if ((start && !busy) || rsp_strobe || keep_count_we)
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("timeout: no progress for %0d cycles", STALL_LIMIT);
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	function automatic cmd_t make_item(logic req, logic [CODE_W-1:0] code,
			logic signed [SCORE_W-1:0] score);
		cmd_t c;
		c.req_type  = req;
		c.rec_code  = code;
		c.rec_score = score;
		return c;
	endfunction

	function automatic cmd_t offer_item();
		logic [63:0] wide;
		int          s;
		cmd_t        c;
		wide = {$urandom, $urandom};
		c.req_type = REQ_OFFER;
		case ($urandom_range(0, 3))
			0: c.rec_code = CODE_W'($urandom_range(0, 7));
			1: c.rec_code = $urandom_range(0, 1) ? '1 : '0;
			default: c.rec_code = wide[CODE_W-1:0];
		endcase
		case ($urandom_range(0, 3))
			0: begin
				s = int'($urandom_range(0, 6)) - 3;
				c.rec_score = s;
			end
			1: c.rec_score = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: c.rec_score = $urandom;
		endcase
		return c;
	endfunction

	function automatic cmd_t drain_item();
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		return make_item(REQ_DRAIN, wide[CODE_W-1:0], $urandom);
	endfunction

	task automatic send_item(cmd_t c);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		start = 1'b1;
		cmd   = c;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic wait_results();
		start = 1'b0;
		while (sb.expected_out.size() != 0)
			@(negedge clk);
	endtask

	// block must be idle: results drained, any rescan finished
	task automatic write_keep(logic [KEEP_W-1:0] v);
		wait_results();
		repeat (SETTLE) @(negedge clk);
		while (busy)
			@(negedge clk);
		keep_count_wdata = v;
		keep_count_we    = 1'b1;
		@(negedge clk);
		keep_count_we    = 1'b0;
	endtask

	initial begin : stimulus
		logic [KEEP_W-1:0] keep_plan [11];
		logic [KEEP_W-1:0] kv;
		int                ph;
		int                i;
		keep_plan = '{7'd3, 7'd32, 7'd1, 7'd64, 7'd127, 7'd0, 7'd5, 7'd8, 7'd31, 7'd33, 7'd16};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty drain, field extremes, equal codes and scores
		send_item(drain_item());
		send_item(make_item(REQ_OFFER, '0, 32'sh8000_0000));
		send_item(make_item(REQ_OFFER, '1, 32'sh7fff_ffff));
		send_item(make_item(REQ_OFFER, '1, 32'sh8000_0000));
		send_item(make_item(REQ_OFFER, 48'd5, 32'sd0));
		send_item(make_item(REQ_OFFER, 48'd5, -32'sd1));
		send_item(make_item(REQ_OFFER, 48'd5, 32'sd0));
		send_item(drain_item());

		// keep 0 acts as 1: exact duplicate dropped, better replaces, worse dropped
		write_keep(7'd0);
		send_item(make_item(REQ_OFFER, 48'd10, 32'sd3));
		send_item(make_item(REQ_OFFER, 48'd10, 32'sd3));
		send_item(make_item(REQ_OFFER, 48'd9, 32'sd3));
		send_item(make_item(REQ_OFFER, 48'd11, 32'sd2));
		send_item(make_item(REQ_OFFER, 48'd0, 32'sd5));
		send_item(drain_item());

		// keep lowered below the number held
		write_keep(7'd127);
		send_item(make_item(REQ_OFFER, 48'd4, 32'sd40));
		send_item(make_item(REQ_OFFER, 48'd3, 32'sd10));
		send_item(make_item(REQ_OFFER, 48'd2, 32'sd30));
		send_item(make_item(REQ_OFFER, 48'd1, 32'sd20));
		write_keep(7'd2);
		send_item(make_item(REQ_OFFER, 48'd7, 32'sd15));
		send_item(make_item(REQ_OFFER, 48'd8, 32'sd99));
		send_item(drain_item());

		for (ph = 0; ph < 11; ph++) begin
			kv = (ph == 6) ? KEEP_W'($urandom_range(0, 127)) : keep_plan[ph];
			write_keep(kv);
			gaps_on = (ph < 9);
			for (i = 0; i < 19; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_item(drain_item());
				else
					send_item(offer_item());
				if (ph == 2 && i == 9)
					wait_results();
			end
			if (ph == 10 || $urandom_range(0, 1) == 1)
				send_item(drain_item());
		end

		wait_results();
		repeat (SETTLE) @(negedge clk);
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
sv/ksel_pkg.sv
sv/ksel_cmp.sv
sv/k_smallest_selector_sorted_drain.sv
test/testbench.sv
